### rtl/core/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

    localparam int WORD_W = 32;

    // Word that ends an append sequence; an append of it is not stored.
    localparam logic signed [WORD_W-1:0] TERMINATOR = -32'sd1;

    // Operation codes carried by an input transfer
    typedef enum logic [2:0] {
        MODE_APPEND     = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_PUSH_BACK  = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_POP_BACK   = 3'd4,
        MODE_DISPLAY    = 3'd5
    } mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_TERM  = 2'd3
    } status_t;

    // Operation applied to every cell of the chain in the same cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE_TAIL,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [WORD_W-1:0]  value;
    } cell_cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_POP,
        ST_DISPLAY
    } state_t;

endpackage

`default_nettype wire

### rtl/core/deq_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface deq_req_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        mode;
    logic signed [deq_pkg::WORD_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [deq_pkg::WORD_W-1:0] word;
    logic                              last;

    modport source (output valid, output status, output word, output last, input ready);
    modport sink   (input valid, input status, input word, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/deq_cell.sv
// One storage cell of the queue chain; trades its word with its neighbors.
`default_nettype none

module deq_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire deq_pkg::cell_cmd_t                cmd,
    input  wire logic signed [deq_pkg::WORD_W-1:0] left_word,
    input  wire logic                              left_valid,
    input  wire logic signed [deq_pkg::WORD_W-1:0] right_word,
    input  wire logic                              right_valid,
    input  wire logic signed [deq_pkg::WORD_W-1:0] head_word,
    output logic signed [deq_pkg::WORD_W-1:0]      word,
    output logic                                   valid
);

    logic signed [deq_pkg::WORD_W-1:0] word_reg;
    logic signed [deq_pkg::WORD_W-1:0] word_next;
    logic                              valid_reg;
    logic                              valid_next;
    logic                              is_tail;
    logic                              is_slot;

    // Tail holds the back element; slot is the first free cell
    assign is_tail = valid_reg && !right_valid;
    assign is_slot = !valid_reg && left_valid;

    // Next cell contents
    always_comb
    begin
        word_next  = word_reg;
        valid_next = valid_reg;
        case (cmd.op)
            deq_pkg::CELL_WRITE_TAIL:
            begin
                if (is_slot)
                begin
                    word_next  = cmd.value;
                    valid_next = 1'b1;
                end
            end
            deq_pkg::CELL_SHIFT_RIGHT:
            begin
                word_next  = left_word;
                valid_next = left_valid;
            end
            deq_pkg::CELL_SHIFT_LEFT:
            begin
                word_next  = right_word;
                valid_next = right_valid;
            end
            deq_pkg::CELL_ROTATE:
            begin
                // occupied span turns left; the head wraps into the tail
                if (valid_reg)
                    word_next = is_tail ? head_word : right_word;
            end
            default:
            begin
                word_next  = word_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Stored word
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

### rtl/core/deq_ctrl.sv
// Sequencer: decodes requests, drives the cell chain, holds the result register.
`default_nettype none

module deq_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    deq_req_if.sink                                req,
    deq_rsp_if.source                              rsp,
    input  wire logic signed [deq_pkg::WORD_W-1:0] head_word,
    output deq_pkg::cell_cmd_t                     cmd
);

    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::state_t  state_reg;
    deq_pkg::state_t  state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    step_reg;
    logic [CW-1:0]    step_next;

    logic                              out_valid_reg;
    logic [1:0]                        out_status_reg;
    logic signed [deq_pkg::WORD_W-1:0] out_word_reg;
    logic                              out_last_reg;

    logic                              slot_free;
    logic                              in_fire;
    logic                              empty;
    logic                              full;
    logic                              step_last;
    logic                              emit;
    deq_pkg::status_t                  emit_status;
    logic signed [deq_pkg::WORD_W-1:0] emit_word;
    logic                              emit_last;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == deq_pkg::ST_IDLE) && slot_free;
    assign in_fire   = req.valid && req.ready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign step_last = (step_reg == count_reg - CW'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (in_fire && !empty)
                begin
                    if (deq_pkg::mode_t'(req.mode) == deq_pkg::MODE_POP_BACK
                        && count_reg != CW'(1))
                        state_next = deq_pkg::ST_ROTATE;
                    else if (deq_pkg::mode_t'(req.mode) == deq_pkg::MODE_DISPLAY)
                        state_next = deq_pkg::ST_DISPLAY;
                end
            end
            deq_pkg::ST_ROTATE:
            begin
                if (step_reg == count_reg - CW'(2))
                    state_next = deq_pkg::ST_POP;
            end
            deq_pkg::ST_POP:
            begin
                if (slot_free)
                    state_next = deq_pkg::ST_IDLE;
            end
            deq_pkg::ST_DISPLAY:
            begin
                if (slot_free && step_last)
                    state_next = deq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    // Chain command, counters and result
    always_comb
    begin
        cmd.op      = deq_pkg::CELL_HOLD;
        cmd.value   = req.value;
        count_next  = count_reg;
        step_next   = step_reg;
        emit        = 1'b0;
        emit_status = deq_pkg::STATUS_OK;
        emit_word   = '0;
        emit_last   = 1'b1;
        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (in_fire)
                begin
                    emit = 1'b1;
                    case (deq_pkg::mode_t'(req.mode))
                        deq_pkg::MODE_APPEND:
                        begin
                            if (req.value == deq_pkg::TERMINATOR)
                                emit_status = deq_pkg::STATUS_TERM;
                            else if (full)
                                emit_status = deq_pkg::STATUS_FULL;
                            else
                            begin
                                cmd.op     = deq_pkg::CELL_WRITE_TAIL;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK:
                        begin
                            if (empty)
                                emit_status = deq_pkg::STATUS_EMPTY;
                            else if (full)
                                emit_status = deq_pkg::STATUS_FULL;
                            else
                            begin
                                cmd.op = (deq_pkg::mode_t'(req.mode)
                                          == deq_pkg::MODE_PUSH_FRONT)
                                       ? deq_pkg::CELL_SHIFT_RIGHT
                                       : deq_pkg::CELL_WRITE_TAIL;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK:
                        begin
                            if (empty)
                                emit_status = deq_pkg::STATUS_EMPTY;
                            else if (deq_pkg::mode_t'(req.mode) == deq_pkg::MODE_POP_FRONT
                                     || count_reg == CW'(1))
                            begin
                                emit_word  = head_word;
                                cmd.op     = deq_pkg::CELL_SHIFT_LEFT;
                                count_next = count_reg - CW'(1);
                            end
                            else
                                emit = 1'b0;  // back element is turned to the head first
                        end
                        deq_pkg::MODE_DISPLAY:
                        begin
                            if (empty)
                                emit_status = deq_pkg::STATUS_EMPTY;
                            else
                                emit = 1'b0;
                        end
                        default:
                        begin
                            emit_status = deq_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            deq_pkg::ST_ROTATE:
            begin
                cmd.op    = deq_pkg::CELL_ROTATE;
                step_next = step_reg + CW'(1);
            end
            deq_pkg::ST_POP:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_word  = head_word;
                    cmd.op     = deq_pkg::CELL_SHIFT_LEFT;
                    count_next = count_reg - CW'(1);
                end
            end
            deq_pkg::ST_DISPLAY:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_word = head_word;
                    emit_last = step_last;
                    cmd.op    = deq_pkg::CELL_ROTATE;
                    step_next = step_reg + CW'(1);
                end
            end
            default:
            begin
                cmd.op = deq_pkg::CELL_HOLD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_word_reg   <= emit_word;
            out_last_reg   <= emit_last;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.word   = out_word_reg;
    assign rsp.last   = out_last_reg;

endmodule

`default_nettype wire

### rtl/core/double_ended_queue.sv
// Double-ended queue of signed 32-bit words stored in a chain of cells.
//
// Requests arrive on req (mode, value), results leave on rsp (status, word,
// last), both valid/ready; a transfer happens when valid and ready are high.
// Elements sit in cells 0..count-1, front in cell 0. All cells act on one shared
// command from the sequencer and trade words with their neighbors under it.
// Append, push, pop front, refusals and spare modes register their result at
// the request transfer, so it shows on rsp the next cycle, and the next request
// can transfer as soon as the result slot is free. Pop back first turns the
// occupied span left count-1 times to bring the back element to cell 0, then
// pops it; with only one element left it pops straight from cell 0. Display
// emits one element per cycle while the receiver takes them, from front to back,
// count results with last on the final one; turning the span count times leaves
// the order intact. One request is in work. A stalled receiver holds the result
// register and pauses the pop and display steps (turning for pop back goes
// on); req.ready stays low until the sequencer is idle and the result slot can
// take the next transfer.
// Reset empties the queue at once (cell valid flags and count cleared).
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    deq_pkg::cell_cmd_t                cmd;
    logic signed [deq_pkg::WORD_W-1:0] cell_word  [DEPTH];
    logic                              cell_valid [DEPTH];

    // Sequencer and result register
    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .head_word (cell_word[0]),
        .cmd       (cmd)
    );

    // Row of cells; the ends see the new value on the left and empty on the right
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [deq_pkg::WORD_W-1:0] lw;
        logic                              lv;
        logic signed [deq_pkg::WORD_W-1:0] rw;
        logic                              rv;

        if (i == 0)
        begin : g_first
            assign lw = cmd.value;
            assign lv = 1'b1;
        end
        else
        begin : g_mid_l
            assign lw = cell_word[i-1];
            assign lv = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_final
            assign rw = '0;
            assign rv = 1'b0;
        end
        else
        begin : g_mid_r
            assign rw = cell_word[i+1];
            assign rv = cell_valid[i+1];
        end

        deq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_word   (lw),
            .left_valid  (lv),
            .right_word  (rw),
            .right_valid (rv),
            .head_word   (cell_word[0]),
            .word        (cell_word[i]),
            .valid       (cell_valid[i])
        );
    end

endmodule

`default_nettype wire

### tb/sv/tb_double_ended_queue.sv
// Self-checking testbench for double_ended_queue: directed table plus random operation sequences.
`default_nettype none

module tb_double_ended_queue;

    localparam int DEPTH          = 16;
    localparam int ITEMS_TOTAL    = 170;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;

    // Mode codes outside the operation set; the block answers them with a plain ok
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct {
        deq_pkg::status_t                  status;
        logic signed [deq_pkg::WORD_W-1:0] word;
        logic                              last;
    } deq_rsp_t;

    typedef struct {
        logic [2:0]                        mode;
        logic signed [deq_pkg::WORD_W-1:0] value;
        bit                                typed;
        deq_pkg::status_t                  status;
        logic signed [deq_pkg::WORD_W-1:0] word;
    } req_row_t;

    logic clk = 1'b0;
    logic rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the queue contents
    logic signed [deq_pkg::WORD_W-1:0] mirror_store [DEPTH];
    logic [3:0]                        mirror_front;
    logic [4:0]                        mirror_count;

    deq_rsp_t pending_rsp [$];

    int items_sent;
    int results_seen;
    int mismatches;
    int empty_refusals;
    int full_refusals;
    int idle_cycles;

    // Directed table: refusals, terminator, extremes, single-element pops, spare modes
    req_row_t dir_rows [23] = '{
        '{deq_pkg::MODE_POP_FRONT,  32'sd0,              1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
        '{deq_pkg::MODE_POP_BACK,   32'sd0,              1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
        '{deq_pkg::MODE_DISPLAY,    32'sd0,              1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
        '{deq_pkg::MODE_PUSH_FRONT, deq_pkg::TERMINATOR, 1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
        '{deq_pkg::MODE_PUSH_BACK,  32'sd1,              1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
        '{deq_pkg::MODE_APPEND,     deq_pkg::TERMINATOR, 1'b1, deq_pkg::STATUS_TERM,  32'sd0},
        '{deq_pkg::MODE_APPEND,     32'sh7FFFFFFF,       1'b1, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_POP_BACK,   32'sd0,              1'b1, deq_pkg::STATUS_OK,
          32'sh7FFFFFFF},
        '{deq_pkg::MODE_POP_FRONT,  32'sd0,              1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
        '{deq_pkg::MODE_APPEND,     32'sh80000000,       1'b1, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_POP_FRONT,  32'sd0,              1'b1, deq_pkg::STATUS_OK,
          32'sh80000000},
        '{deq_pkg::MODE_APPEND,     32'sd0,              1'b1, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_PUSH_FRONT, deq_pkg::TERMINATOR, 1'b1, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_PUSH_BACK,  32'sh55555555,       1'b1, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_PUSH_FRONT, 32'shAAAAAAAA,       1'b1, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_DISPLAY,    32'sd0,              1'b0, deq_pkg::STATUS_OK,    32'sd0},
        '{MODE_SPARE_6,             32'sh12345678,       1'b1, deq_pkg::STATUS_OK,    32'sd0},
        '{MODE_SPARE_7,             deq_pkg::TERMINATOR, 1'b1, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_POP_BACK,   32'sd0,              1'b0, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_POP_FRONT,  32'sd0,              1'b0, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_DISPLAY,    32'sd0,              1'b0, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_POP_FRONT,  32'sd0,              1'b0, deq_pkg::STATUS_OK,    32'sd0},
        '{deq_pkg::MODE_POP_BACK,   32'sd0,              1'b0, deq_pkg::STATUS_OK,    32'sd0}
    };

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Reset, once at the start
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Gap draw per transfer; every third stretch of 20 runs without gaps
    function automatic int draw_gap(input int n);
        if ((n / 20) % 3 == 2)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic signed [deq_pkg::WORD_W-1:0] draw_word();
        case ($urandom_range(0, 15))
            0:       return deq_pkg::TERMINATOR;
            1:       return 32'sh7FFFFFFF;
            2:       return 32'sh80000000;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_rsp(input deq_pkg::status_t s,
                                      input logic signed [deq_pkg::WORD_W-1:0] w,
                                      input logic l);
        deq_rsp_t r;
        r.status = s;
        r.word   = w;
        r.last   = l;
        pending_rsp.push_back(r);
        if (s == deq_pkg::STATUS_EMPTY)
            empty_refusals++;
        if (s == deq_pkg::STATUS_FULL)
            full_refusals++;
    endfunction

    // Expected results of one request; updates the mirror
    function automatic void predict_deq(input logic [2:0] m,
                                        input logic signed [deq_pkg::WORD_W-1:0] v);
        logic [3:0]                        slot;
        logic signed [deq_pkg::WORD_W-1:0] w;
        bit                                is_empty;
        bit                                is_full;
        is_empty = (mirror_count == 5'd0);
        is_full  = (mirror_count >= 5'(DEPTH));
        case (m)
            deq_pkg::MODE_APPEND:
            begin
                if (v == deq_pkg::TERMINATOR)
                    queue_rsp(deq_pkg::STATUS_TERM, '0, 1'b1);
                else if (is_full)
                    queue_rsp(deq_pkg::STATUS_FULL, '0, 1'b1);
                else
                begin
                    slot = 4'(mirror_front + mirror_count);
                    mirror_store[slot] = v;
                    mirror_count++;
                    queue_rsp(deq_pkg::STATUS_OK, '0, 1'b1);
                end
            end
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK:
            begin
                if (is_empty)
                    queue_rsp(deq_pkg::STATUS_EMPTY, '0, 1'b1);
                else if (is_full)
                    queue_rsp(deq_pkg::STATUS_FULL, '0, 1'b1);
                else
                begin
                    if (m == deq_pkg::MODE_PUSH_FRONT)
                    begin
                        mirror_front = mirror_front - 4'd1;
                        mirror_store[mirror_front] = v;
                    end
                    else
                    begin
                        slot = 4'(mirror_front + mirror_count);
                        mirror_store[slot] = v;
                    end
                    mirror_count++;
                    queue_rsp(deq_pkg::STATUS_OK, '0, 1'b1);
                end
            end
            deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK:
            begin
                if (is_empty)
                    queue_rsp(deq_pkg::STATUS_EMPTY, '0, 1'b1);
                else
                begin
                    if (m == deq_pkg::MODE_POP_FRONT)
                    begin
                        w = mirror_store[mirror_front];
                        mirror_front = mirror_front + 4'd1;
                    end
                    else
                    begin
                        slot = 4'(mirror_front + mirror_count - 5'd1);
                        w = mirror_store[slot];
                    end
                    mirror_count--;
                    // last element gone: front returns to zero
                    if (mirror_count == 5'd0)
                        mirror_front = 4'd0;
                    queue_rsp(deq_pkg::STATUS_OK, w, 1'b1);
                end
            end
            deq_pkg::MODE_DISPLAY:
            begin
                if (is_empty)
                    queue_rsp(deq_pkg::STATUS_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < int'(mirror_count); i++)
                    begin
                        slot = 4'(mirror_front + 4'(i));
                        queue_rsp(deq_pkg::STATUS_OK, mirror_store[slot],
                                  i == int'(mirror_count) - 1);
                    end
            end
            default:
                queue_rsp(deq_pkg::STATUS_OK, '0, 1'b1);
        endcase
    endfunction

    // One request transfer; a typed row overrides status and word of the predicted single result
    task automatic send_req(input logic [2:0] m, input logic signed [deq_pkg::WORD_W-1:0] v,
                            input bit typed, input deq_pkg::status_t t_status,
                            input logic signed [deq_pkg::WORD_W-1:0] t_word);
        int gap;
        gap = draw_gap(items_sent);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= m;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        items_sent++;
        predict_deq(m, v);
        if (typed)
        begin
            pending_rsp[pending_rsp.size() - 1].status = t_status;
            pending_rsp[pending_rsp.size() - 1].word   = t_word;
        end
    endtask

    task automatic send_plain(input logic [2:0] m,
                              input logic signed [deq_pkg::WORD_W-1:0] v);
        send_req(m, v, 1'b0, deq_pkg::STATUS_OK, '0);
    endtask

    // Initial drive of all inputs
    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.mode  <= deq_pkg::MODE_APPEND;
        req_ch.value <= '0;
        rsp_ch.ready <= 1'b0;
    end

    // Request side: directed table, then random operation sequences
    initial
    begin
        int kind;
        logic [2:0] m;
        items_sent     = 0;
        mismatches     = 0;
        empty_refusals = 0;
        full_refusals  = 0;
        mirror_front   = '0;
        mirror_count   = '0;
        foreach (mirror_store[i])
            mirror_store[i] = '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed,
                     dir_rows[i].status, dir_rows[i].word);

        while (items_sent < ITEMS_TOTAL)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 3)
            begin
                // fill to full, then knock on the full store and show it
                while (mirror_count < 5'(DEPTH))
                    send_plain(deq_pkg::MODE_APPEND, draw_word());
                repeat ($urandom_range(1, 3))
                begin
                    m = 3'($urandom_range(deq_pkg::MODE_APPEND, deq_pkg::MODE_PUSH_BACK));
                    send_plain(m, draw_word());
                end
                send_plain(deq_pkg::MODE_DISPLAY, draw_word());
            end
            else if (kind < 5)
            begin
                // drain from both ends, then one request on the empty queue
                while (mirror_count != 5'd0)
                begin
                    m = $urandom_range(0, 1) ? deq_pkg::MODE_POP_FRONT : deq_pkg::MODE_POP_BACK;
                    send_plain(m, draw_word());
                end
                m = 3'($urandom_range(deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_DISPLAY));
                send_plain(m, draw_word());
            end
            else if (kind < 9)
            begin
                // mixed operations
                repeat (8)
                begin
                    m = 3'($urandom_range(deq_pkg::MODE_APPEND, deq_pkg::MODE_DISPLAY));
                    send_plain(m, draw_word());
                end
            end
            else
            begin
                // spare mode codes
                repeat ($urandom_range(1, 3))
                begin
                    m = 3'($urandom_range(MODE_SPARE_6, MODE_SPARE_7));
                    send_plain(m, draw_word());
                end
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d results, %0d empty and %0d full refusals.",
                 items_sent, results_seen, empty_refusals, full_refusals);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random stalls, compare each transfer with the oldest expectation
    initial
    begin
        deq_rsp_t exp_r;
        int gap;
        results_seen = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(results_seen);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            results_seen++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %0d: status %0d word %0d last %0d",
                             results_seen, rsp_ch.status, rsp_ch.word, rsp_ch.last);
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (rsp_ch.status !== exp_r.status || rsp_ch.word !== exp_r.word
                    || rsp_ch.last !== exp_r.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result %0d mismatch: expected status %0d word %0d ",
                                  "last %0d, got status %0d word %0d last %0d"},
                                 results_seen, exp_r.status, exp_r.word, exp_r.last,
                                 rsp_ch.status, rsp_ch.word, rsp_ch.last);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            idle_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

`default_nettype wire
